>>> sv/lr_pkg.sv
// Shared types and constants of the line rasterizer.
package lr_pkg;

  localparam int COORD_BITS  = 6;
  localparam int COLOR_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  // Remainder spans [-d, 2d): two bits over a coordinate, signed.
  localparam int REM_BITS    = COORD_BITS + 2;

  localparam logic [COLOR_BITS-1:0] COLOR_RESET = '1;

  // One segment as it arrives on the input channel.
  typedef struct packed {
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
  } seg_t;

  // One pixel as it leaves on the output channel.
  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_pixel;
  } pixel_t;

  // Classified segment: major axis ascending from p0 over d steps,
  // minor axis starting at m0 and moving by delta over the whole run.
  typedef struct packed {
    logic                  steep;
    logic [COORD_BITS-1:0] p0;
    logic [COORD_BITS-1:0] d;
    logic [COORD_BITS-1:0] m0;
    logic [COORD_BITS:0]   delta;
  } job_t;

endpackage

>>> sv/lr_queue.sv
// Short job queue between the classifier and the stepper.
module lr_queue import lr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t push_job,
  input  logic push_valid,
  output logic push_ready,
  output job_t pop_job,
  output logic pop_valid,
  input  logic pop_ready
);

  job_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the incoming job.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

>>> sv/lr_front.sv
// Front end: accepts segments, picks the major axis and orders endpoints.
module lr_front import lr_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  seg_t seg,
  input  logic seg_valid,
  output logic seg_ready,
  output job_t job,
  output logic job_valid,
  input  logic job_ready
);

  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;
  logic                  steep;
  logic [COORD_BITS-1:0] a_maj;
  logic [COORD_BITS-1:0] a_min;
  logic [COORD_BITS-1:0] b_maj;
  logic [COORD_BITS-1:0] b_min;
  job_t                  job_next;

  assign seg_ready = !job_valid || job_ready;

  // Classify the segment.
  always_comb begin
    adx   = (seg.start_x > seg.end_x) ? seg.start_x - seg.end_x : seg.end_x - seg.start_x;
    ady   = (seg.start_y > seg.end_y) ? seg.start_y - seg.end_y : seg.end_y - seg.start_y;
    steep = adx < ady;
    if (steep) begin
      a_maj = seg.start_y;
      a_min = seg.start_x;
      b_maj = seg.end_y;
      b_min = seg.end_x;
    end else begin
      a_maj = seg.start_x;
      a_min = seg.start_y;
      b_maj = seg.end_x;
      b_min = seg.end_y;
    end
    job_next.steep = steep;
    if (a_maj > b_maj) begin
      job_next.p0    = b_maj;
      job_next.d     = a_maj - b_maj;
      job_next.m0    = b_min;
      job_next.delta = {1'b0, a_min} - {1'b0, b_min};
    end else begin
      job_next.p0    = a_maj;
      job_next.d     = b_maj - a_maj;
      job_next.m0    = a_min;
      job_next.delta = {1'b0, b_min} - {1'b0, a_min};
    end
  end

  // Hold the classified job until the queue takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (seg_ready) begin
      job_valid <= seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_valid && seg_ready) begin
      job <= job_next;
    end
  end

endmodule

>>> sv/lr_back.sv
// Back end: steps along the major axis and emits one pixel per step.
module lr_back import lr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  job_t                  job,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  logic [COLOR_BITS-1:0] color,
  output pixel_t                pix,
  output logic                  pix_valid,
  input  logic                  pix_ready
);

  logic                       busy;
  logic                       steep;
  logic [COORD_BITS-1:0]      major;
  logic [COORD_BITS-1:0]      minor;
  logic signed [REM_BITS-1:0] rem;
  logic [COORD_BITS-1:0]      left;
  logic [COORD_BITS-1:0]      d;
  logic [COORD_BITS:0]        delta;
  logic                       start;
  logic                       advance;
  logic signed [REM_BITS-1:0] rem_sum;
  logic signed [REM_BITS-1:0] d_ext;

  assign job_ready = !busy;
  assign start     = !busy && job_valid;
  assign advance   = busy && (!pix_valid || pix_ready);

  // The minor value is quotient minor plus rem/d; each step adds delta
  // (|delta| <= d), so one correction keeps rem in [0, d).
  assign d_ext   = $signed({2'b00, d});
  assign rem_sum = rem + $signed({delta[COORD_BITS], delta});

  // Track the segment in progress and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pix_valid <= 1'b0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (advance && left == '0) begin
        busy <= 1'b0;
      end
      if (advance) begin
        pix_valid <= 1'b1;
      end else if (pix_ready) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Load a new segment, or emit the current pixel and step.
  always_ff @(posedge clk) begin
    if (start) begin
      steep <= job.steep;
      major <= job.p0;
      minor <= job.m0;
      rem   <= '0;
      left  <= job.d;
      d     <= job.d;
      delta <= job.delta;
    end else if (advance) begin
      pix.pixel_x     <= steep ? minor : major;
      pix.pixel_y     <= steep ? major : minor;
      pix.pixel_color <= color;
      pix.last_pixel  <= (left == '0);
      major           <= major + 1'b1;
      left            <= left - 1'b1;
      priority if (rem_sum >= d_ext) begin
        rem   <= rem_sum - d_ext;
        minor <= minor + 1'b1;
      end else if (rem_sum < 0) begin
        rem   <= rem_sum + d_ext;
        minor <= minor - 1'b1;
      end else begin
        rem <= rem_sum;
      end
    end
  end

endmodule

>>> sv/line_rasterizer_top.sv
// Top level of the tile line rasterizer.
//
// Segment channel (seg_valid/seg_ready, seg): two endpoints in tile
// coordinates. Pixel channel (pix_valid/pix_ready, pix): one pixel per
// major-axis step, d+1 pixels for a segment whose major-axis distance is
// d, the final one marked by last_pixel. Config channel (cfg_valid,
// cfg_ready, cfg_data): the draw color, always ready, written while idle.
// When the block is empty, an accepted segment passes the front-end job
// register, the queue and the stepper load before its first pixel enters
// the output register. The stepper emits one pixel per cycle unless the
// receiver stalls, and loads the next segment after the last pixel.
// The front end and a two-entry queue keep accepting segments meanwhile.
// Reset clears the queue, the stepper and the output register and sets
// the draw color to all ones. When the receiver stalls, the pixel holds
// in the output register and the stepper waits; segments fill the queue
// and then the front-end job register, after which seg_ready drops.
module line_rasterizer_top import lr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  seg_t                  seg,
  input  logic                  seg_valid,
  output logic                  seg_ready,
  output pixel_t                pix,
  output logic                  pix_valid,
  input  logic                  pix_ready,
  input  logic [COLOR_BITS-1:0] cfg_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready
);

  logic [COLOR_BITS-1:0] draw_color;
  job_t                  front_job;
  logic                  front_valid;
  logic                  front_ready;
  job_t                  queue_job;
  logic                  queue_valid;
  logic                  queue_ready;

  assign cfg_ready = 1'b1;

  // Hold the draw color register.
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_color <= COLOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      draw_color <= cfg_data;
    end
  end

  lr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .seg       (seg),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  lr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (queue_job),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready)
  );

  lr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (queue_job),
    .job_valid (queue_valid),
    .job_ready (queue_ready),
    .color     (draw_color),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready)
  );

endmodule

>>> sv/lr_checker.sv
// Port-level checks of the line rasterizer and their binding.
module lr_checker import lr_pkg::*; (
  input logic   clk,
  input logic   rst,
  input pixel_t pix,
  input logic   pix_valid,
  input logic   pix_ready
);

  // Keep a stalled pixel transaction pending.
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid && $stable(pix))
    else $error("pixel dropped or changed while stalled");

  // Drop the output after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel valid right after reset");

  // Follow a non-final pixel with the next one at once.
  a_run_on: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !pix.last_pixel |=> pix_valid)
    else $error("gap inside a segment");

  // Step each coordinate by at most one inside a segment.
  a_adjacent: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && !pix.last_pixel |=>
      (pix.pixel_x == $past(pix.pixel_x) ||
       pix.pixel_x == $past(pix.pixel_x) + 6'd1 ||
       pix.pixel_x == $past(pix.pixel_x) - 6'd1) &&
      (pix.pixel_y == $past(pix.pixel_y) ||
       pix.pixel_y == $past(pix.pixel_y) + 6'd1 ||
       pix.pixel_y == $past(pix.pixel_y) - 6'd1))
    else $error("pixels of a segment not adjacent");

endmodule

bind line_rasterizer_top lr_checker u_lr_checker (
  .clk       (clk),
  .rst       (rst),
  .pix       (pix),
  .pix_valid (pix_valid),
  .pix_ready (pix_ready)
);

>>> tb/line_rasterizer_checker.sv
`timescale 1ns / 1ps
// Pixel predictor and scoreboard that watches the line rasterizer channels.
module line_rasterizer_checker import lr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  seg_t                  seg,
  input  logic                  seg_valid,
  input  logic                  seg_ready,
  input  pixel_t                pix,
  input  logic                  pix_valid,
  input  logic                  pix_ready,
  input  logic [COLOR_BITS-1:0] cfg_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  output int                    fail_count,
  output int                    pending
);

  localparam int PRINT_CAP = 100;

  logic [COLOR_BITS-1:0] draw_color_q = COLOR_RESET;
  pixel_t                expected_pixels[$];
  int                    mismatches = 0;

  assign fail_count = mismatches;

  // Print one line per mismatch (up to a cap) and count it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Walk the major axis of one segment and queue its pixels.
  task automatic rasterize_segment(input seg_t s);
    int     ax, ay, bx, by, adx, ady;
    int     p0, m0, p1, m1, tmp, d, minor;
    bit     steep;
    pixel_t px;
    ax = s.start_x;
    ay = s.start_y;
    bx = s.end_x;
    by = s.end_y;
    adx = (ax > bx) ? ax - bx : bx - ax;
    ady = (ay > by) ? ay - by : by - ay;
    // Ties go to x as the major axis.
    steep = (adx < ady);
    if (steep) begin
      p0 = ay; m0 = ax; p1 = by; m1 = bx;
    end else begin
      p0 = ax; m0 = ay; p1 = bx; m1 = by;
    end
    // Order endpoints so the major axis ascends.
    if (p0 > p1) begin
      tmp = p0; p0 = p1; p1 = tmp;
      tmp = m0; m0 = m1; m1 = tmp;
    end
    d = p1 - p0;
    for (int k = 0; k <= d; k++) begin
      // A zero-length segment emits its single point with no division.
      if (d == 0)
        minor = m0;
      else
        minor = (m0 * (d - k) + m1 * k) / d;
      if (steep) begin
        px.pixel_x = COORD_BITS'(minor);
        px.pixel_y = COORD_BITS'(p0 + k);
      end else begin
        px.pixel_x = COORD_BITS'(p0 + k);
        px.pixel_y = COORD_BITS'(minor);
      end
      px.pixel_color = draw_color_q;
      px.last_pixel  = (k == d);
      expected_pixels.push_back(px);
    end
  endtask

  // Compare one delivered pixel with the oldest expected one.
  task automatic check_pixel(input pixel_t got);
    pixel_t want;
    if (expected_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel x=%0d y=%0d color=%h last=%0b",
                                got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel));
    end else begin
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
          got.pixel_color !== want.pixel_color || got.last_pixel !== want.last_pixel)
        report_mismatch($sformatf(
          "pixel got x=%0d y=%0d color=%h last=%0b, want x=%0d y=%0d color=%h last=%0b",
          got.pixel_x, got.pixel_y, got.pixel_color, got.last_pixel,
          want.pixel_x, want.pixel_y, want.pixel_color, want.last_pixel));
    end
  endtask

  // Track color writes, check delivered pixels, predict accepted segments.
  always @(posedge clk) begin
    if (rst) begin
      draw_color_q = COLOR_RESET;
      expected_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        draw_color_q = cfg_data;
      if (pix_valid && pix_ready)
        check_pixel(pix);
      if (seg_valid && seg_ready)
        rasterize_segment(seg);
    end
    pending = expected_pixels.size();
  end

endmodule

>>> tb/tb_line_rasterizer_top.sv
`timescale 1ns / 1ps
// Testbench top: drives segments, color writes and pixel back-pressure, and gives the verdict.
module tb_line_rasterizer_top import lr_pkg::*; ();

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 25;
  localparam int SETTLE_CYCLES = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  seg_t                  seg = '0;
  logic                  seg_valid = 1'b0;
  logic                  seg_ready;
  pixel_t                pix;
  logic                  pix_valid;
  logic                  pix_ready = 1'b0;
  logic [COLOR_BITS-1:0] cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  int                    fail_count;
  int                    pending;
  int                    cycles = 0;
  int                    burst_left = 1;
  int                    ready_mode = 0;
  int                    ready_tick = 0;

  line_rasterizer_top dut (
    .clk       (clk),
    .rst       (rst),
    .seg       (seg),
    .seg_valid (seg_valid),
    .seg_ready (seg_ready),
    .pix       (pix),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .cfg_data  (cfg_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
  );

  line_rasterizer_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .seg        (seg),
    .seg_valid  (seg_valid),
    .seg_ready  (seg_ready),
    .pix        (pix),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Drive pix_ready from one of four patterns (always ready, or random or periodic stalls), chosen at random.
  always @(negedge clk) begin
    if (ready_tick % 150 == 0)
      ready_mode = $urandom_range(0, 3);
    ready_tick++;
    case (ready_mode)
      0: pix_ready = 1'b1;
      1: pix_ready = ($urandom_range(0, 3) != 0);
      2: pix_ready = (ready_tick % 5 == 0);
      default: pix_ready = ($urandom_range(0, 1) != 0);
    endcase
  end

  // Present one segment and hold it until the transaction completes.
  task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
    seg.start_x = COORD_BITS'(sx);
    seg.start_y = COORD_BITS'(sy);
    seg.end_x   = COORD_BITS'(ex);
    seg.end_y   = COORD_BITS'(ey);
    seg_valid   = 1'b1;
    do @(posedge clk); while (!seg_ready);
    @(negedge clk);
  endtask

  // Send one random segment; when the burst ends, drop valid for a random gap, which may be none.
  task automatic send_random_segment();
    int sx, sy, ex, ey, shape, len, tmp, gap;
    sx = $urandom_range(0, 63);
    sy = $urandom_range(0, 63);
    ex = $urandom_range(0, 63);
    ey = $urandom_range(0, 63);
    shape = $urandom_range(0, 9);
    case (shape)
      4, 5: begin
        ex = sx + $urandom_range(0, 6) - 3;
        ey = sy + $urandom_range(0, 6) - 3;
        ex = (ex < 0) ? 0 : (ex > 63) ? 63 : ex;
        ey = (ey < 0) ? 0 : (ey > 63) ? 63 : ey;
      end
      6: ey = sy;
      7: ex = sx;
      8: begin
        // Equal x and y distances.
        len = $urandom_range(0, 63);
        sx = $urandom_range(0, 63 - len);
        sy = $urandom_range(0, 63 - len);
        ex = sx + len;
        ey = sy + len;
        if ($urandom_range(0, 1)) begin
          tmp = sx; sx = ex; ex = tmp;
        end
        if ($urandom_range(0, 1)) begin
          tmp = sy; sy = ey; ey = tmp;
        end
      end
      9: begin
        ex = sx;
        ey = sy;
      end
      default: ;
    endcase
    send_segment(sx, sy, ex, ey);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        seg_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
  endtask

  // Write the draw color while the block is idle.
  task automatic write_color(input logic [COLOR_BITS-1:0] color);
    cfg_data  = color;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain all expected pixels, then let the pipeline settle.
  task automatic wait_idle();
    seg_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random phase under one color setting.
  task automatic run_phase(input logic [COLOR_BITS-1:0] color);
    write_color(color);
    repeat (PHASE_ITEMS) send_random_segment();
    wait_idle();
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed segments, back to back, under the reset color.
    send_segment(0, 0, 0, 0);
    send_segment(63, 63, 63, 63);
    send_segment(0, 0, 63, 0);
    send_segment(63, 63, 0, 63);
    send_segment(0, 0, 0, 63);
    send_segment(63, 63, 63, 0);
    send_segment(0, 0, 63, 63);
    send_segment(63, 0, 0, 63);
    send_segment(0, 63, 63, 0);
    send_segment(5, 10, 20, 13);
    send_segment(20, 13, 5, 10);
    send_segment(10, 5, 13, 20);
    send_segment(13, 20, 10, 5);
    send_segment(0, 0, 1, 63);
    send_segment(0, 0, 63, 1);
    send_segment(62, 1, 63, 0);
    send_segment(30, 30, 31, 30);
    send_segment(30, 30, 30, 31);
    send_segment(7, 40, 50, 3);
    send_segment(21, 42, 42, 21);
    wait_idle();

    // Random segments over several color settings, extremes included.
    run_phase('0);
    run_phase('1);
    run_phase($urandom);
    run_phase($urandom);

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
